@@ rtl/rk4_mass_spring_damper_step_defines.svh @@
// Assertion macros shared by the checker files of the integrator block.
`ifndef RK4_MASS_SPRING_DAMPER_STEP_DEFINES_SVH
`define RK4_MASS_SPRING_DAMPER_STEP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RK4_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rk4 msd check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RK4_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rk4 msd check failed");

`endif

@@ rtl/rk4msd_pkg.sv @@
// Shared types, constants, micro-program and helpers for the RK4 integrator.
package rk4msd_pkg;

    localparam int AXES   = 3;
    localparam int IN_W   = 96;
    localparam int OUT_W  = 296;
    localparam int PROG_LEN = 34;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_STIFFNESS  = 3'd0;
    localparam logic [2:0] REG_DAMPING    = 3'd1;
    localparam logic [2:0] REG_INV_MASS_X = 3'd2;
    localparam logic [2:0] REG_INV_MASS_Y = 3'd3;
    localparam logic [2:0] REG_INV_MASS_Z = 3'd4;
    localparam logic [2:0] REG_FORCE_X    = 3'd5;
    localparam logic [2:0] REG_FORCE_Y    = 3'd6;
    localparam logic [2:0] REG_FORCE_Z    = 3'd7;

    // Action codes carried in s_tuser
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Step constants, unsigned Q0.32
    localparam logic [22:0] DT_Q32  = 23'd4294967;
    localparam logic [22:0] HDT_Q32 = 23'd2147484;
    localparam logic [22:0] DT6_Q32 = 23'd715828;

    typedef enum logic [3:0] {
        OP_INIT,
        OP_P,
        OP_Q,
        OP_S,
        OP_F,
        OP_ACC1,
        OP_ACC2,
        OP_DTX_H,
        OP_DTV_H,
        OP_DTX_F,
        OP_DTV_F,
        OP_FX,
        OP_FV,
        OP_STORE
    } op_t;

    typedef struct packed {
        logic       issue;
        logic       write;
        logic       load;
        logic       publish;
        logic [1:0] ax;
        op_t        op;
    } cmd_t;

    // Micro-program for one axis of one step
    function automatic op_t prog_op(input logic [5:0] pc);
        op_t o;
        unique case (pc)
            6'd0:  o = OP_INIT;
            6'd1, 6'd8, 6'd15, 6'd22, 6'd29:  o = OP_P;
            6'd2, 6'd9, 6'd16, 6'd23, 6'd30:  o = OP_Q;
            6'd3, 6'd10, 6'd17, 6'd24, 6'd31: o = OP_S;
            6'd4, 6'd11, 6'd18, 6'd25, 6'd32: o = OP_F;
            6'd5, 6'd26:   o = OP_ACC1;
            6'd12, 6'd19:  o = OP_ACC2;
            6'd6, 6'd13:   o = OP_DTX_H;
            6'd7, 6'd14:   o = OP_DTV_H;
            6'd20:         o = OP_DTX_F;
            6'd21:         o = OP_DTV_F;
            6'd27:         o = OP_FX;
            6'd28:         o = OP_FV;
            default:       o = OP_STORE;
        endcase
        return o;
    endfunction

    // Clamp a wide value to the signed 32-bit range
    function automatic logic signed [31:0] clip32(input logic signed [69:0] v);
        logic signed [31:0] r;
        if (v > 70'sh0_0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -70'sh0_0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [69:0] v);
        return (v > 70'sh0_0000_0000_7FFF_FFFF) || (v < -70'sh0_0000_0000_8000_0000);
    endfunction

endpackage

@@ rtl/rk4msd_ctrl.sv @@
// Controller: handshakes, micro-program counter and axis sequencing.
module rk4msd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                action,
    output logic                m_tvalid,
    input  logic                m_tready,
    output rk4msd_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } state_t;

    state_t     state_reg, state_next;
    logic       phase_reg, phase_next;
    logic [5:0] pc_reg, pc_next;
    logic [1:0] ax_reg, ax_next;
    logic       mvalid_reg, mvalid_next;
    logic       publish;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign publish  = (state_reg == ST_FLUSH) && (!mvalid_reg || m_tready);

    // Drive datapath commands
    always_comb
    begin
        cmd.issue   = (state_reg == ST_RUN) && !phase_reg;
        cmd.write   = (state_reg == ST_RUN) && phase_reg;
        cmd.load    = (state_reg == ST_IDLE) && s_tvalid && (action == rk4msd_pkg::ACT_LOAD);
        cmd.publish = publish;
        cmd.ax      = ax_reg;
        cmd.op      = rk4msd_pkg::prog_op(pc_reg);
    end

    // Sequence items and micro-ops
    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        pc_next     = pc_reg;
        ax_next     = ax_reg;
        mvalid_next = mvalid_reg;
        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    if (action == rk4msd_pkg::ACT_STEP) begin
                        state_next = ST_RUN;
                        phase_next = 1'b0;
                        pc_next    = '0;
                        ax_next    = '0;
                    end
                    else begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_RUN:
            begin
                phase_next = !phase_reg;
                if (phase_reg) begin
                    if (pc_reg == 6'(rk4msd_pkg::PROG_LEN - 1)) begin
                        pc_next = '0;
                        ax_next = ax_reg + 2'd1;
                        if (ax_reg == 2'(rk4msd_pkg::AXES - 1)) begin
                            state_next = ST_FLUSH;
                        end
                    end
                    else begin
                        pc_next = pc_reg + 6'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (publish) begin
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= 1'b0;
            pc_reg     <= '0;
            ax_reg     <= '0;
            mvalid_reg <= 1'b0;
        end
        else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pc_reg     <= pc_next;
            ax_reg     <= ax_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

@@ rtl/rk4msd_dp.sv @@
// Datapath: configuration, state, shared multiplier, rounding and clamping.
module rk4msd_dp #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rk4msd_pkg::cmd_t                    cmd,
    input  logic [rk4msd_pkg::IN_W-1:0]         start,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_addr,
    input  logic [31:0]                         cfg_wdata,
    output logic [rk4msd_pkg::OUT_W-1:0]        result
);

    localparam logic [30:0] ONE_Q = 31'(1) << FRAC_BITS;

    logic [30:0]        stiff_reg, damp_reg;
    logic [30:0]        inv_reg [rk4msd_pkg::AXES];
    logic signed [31:0] force_reg [rk4msd_pkg::AXES];
    logic signed [31:0] pos_reg [rk4msd_pkg::AXES];
    logic signed [31:0] vel_reg [rk4msd_pkg::AXES];
    logic signed [31:0] acc_reg [rk4msd_pkg::AXES];
    logic               sat_reg, sat_next;

    logic signed [31:0] x_reg, v_reg, xe_reg, ve_reg, p_reg, q_reg, kv_reg;
    logic signed [35:0] sx_reg, sv_reg;
    logic signed [68:0] prod_reg;
    logic [rk4msd_pkg::OUT_W-1:0] result_reg;

    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic [22:0]        kconst;
    logic               frac_shift;
    logic [68:0]        mag;
    logic [69:0]        mag_q, mag_d;
    logic [68:0]        rmag;
    logic signed [69:0] rnd, base, sum;
    logic signed [31:0] clipped;
    logic               ovf;

    // Select the step constant
    always_comb
    begin
        unique case (cmd.op)
            rk4msd_pkg::OP_DTX_F, rk4msd_pkg::OP_DTV_F: kconst = rk4msd_pkg::DT_Q32;
            rk4msd_pkg::OP_FX, rk4msd_pkg::OP_FV:       kconst = rk4msd_pkg::DT6_Q32;
            default:                                    kconst = rk4msd_pkg::HDT_Q32;
        endcase
    end

    // Select multiplier operands
    always_comb
    begin
        unique case (cmd.op)
            rk4msd_pkg::OP_P:
            begin
                mul_a = 36'(ve_reg);
                mul_b = $signed({2'b00, damp_reg});
            end
            rk4msd_pkg::OP_Q:
            begin
                mul_a = 36'(xe_reg);
                mul_b = $signed({2'b00, stiff_reg});
            end
            rk4msd_pkg::OP_F:
            begin
                mul_a = 36'(p_reg);
                mul_b = $signed({2'b00, inv_reg[cmd.ax]});
            end
            rk4msd_pkg::OP_DTX_H, rk4msd_pkg::OP_DTX_F:
            begin
                mul_a = 36'(ve_reg);
                mul_b = $signed({10'd0, kconst});
            end
            rk4msd_pkg::OP_DTV_H, rk4msd_pkg::OP_DTV_F:
            begin
                mul_a = 36'(kv_reg);
                mul_b = $signed({10'd0, kconst});
            end
            rk4msd_pkg::OP_FX:
            begin
                mul_a = sx_reg;
                mul_b = $signed({10'd0, kconst});
            end
            rk4msd_pkg::OP_FV:
            begin
                mul_a = sv_reg;
                mul_b = $signed({10'd0, kconst});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round half away from zero, then add base and clamp; OP_S instead clamps force minus p and q
    always_comb
    begin
        frac_shift = (cmd.op == rk4msd_pkg::OP_P) || (cmd.op == rk4msd_pkg::OP_Q)
                     || (cmd.op == rk4msd_pkg::OP_F);
        mag   = prod_reg[68] ? (~prod_reg + 69'd1) : prod_reg;
        mag_q = (70'(mag) + (70'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        mag_d = (70'(mag) + (70'(1) << 31)) >> 32;
        rmag  = frac_shift ? mag_q[68:0] : mag_d[68:0];
        rnd   = prod_reg[68] ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
        unique case (cmd.op)
            rk4msd_pkg::OP_DTX_H, rk4msd_pkg::OP_DTX_F, rk4msd_pkg::OP_FX:
                base = 70'(x_reg);
            rk4msd_pkg::OP_DTV_H, rk4msd_pkg::OP_DTV_F, rk4msd_pkg::OP_FV:
                base = 70'(v_reg);
            default:
                base = '0;
        endcase
        if (cmd.op == rk4msd_pkg::OP_S) begin
            sum = 70'(force_reg[cmd.ax]) - 70'(p_reg) - 70'(q_reg);
        end
        else begin
            sum = base + rnd;
        end
        clipped = rk4msd_pkg::clip32(sum);
        ovf     = rk4msd_pkg::ovf32(sum);
    end

    // Flag any clamp during the item
    always_comb
    begin
        sat_next = sat_reg;
        if (cmd.load || (cmd.write && (cmd.op == rk4msd_pkg::OP_INIT) && (cmd.ax == 2'd0))) begin
            sat_next = 1'b0;
        end
        else if (cmd.write && (cmd.op != rk4msd_pkg::OP_INIT) && (cmd.op != rk4msd_pkg::OP_STORE)
                 && (cmd.op != rk4msd_pkg::OP_ACC1) && (cmd.op != rk4msd_pkg::OP_ACC2)) begin
            sat_next = sat_reg | ovf;
        end
    end

    // Hold configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stiff_reg <= '0;
            damp_reg  <= '0;
            sat_reg   <= 1'b0;
            for (int i = 0; i < rk4msd_pkg::AXES; i++) begin
                inv_reg[i]   <= ONE_Q;
                force_reg[i] <= '0;
                pos_reg[i]   <= '0;
                vel_reg[i]   <= '0;
                acc_reg[i]   <= '0;
            end
        end
        else begin
            sat_reg <= sat_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    rk4msd_pkg::REG_STIFFNESS:  stiff_reg    <= cfg_wdata[30:0];
                    rk4msd_pkg::REG_DAMPING:    damp_reg     <= cfg_wdata[30:0];
                    rk4msd_pkg::REG_INV_MASS_X: inv_reg[0]   <= cfg_wdata[30:0];
                    rk4msd_pkg::REG_INV_MASS_Y: inv_reg[1]   <= cfg_wdata[30:0];
                    rk4msd_pkg::REG_INV_MASS_Z: inv_reg[2]   <= cfg_wdata[30:0];
                    rk4msd_pkg::REG_FORCE_X:    force_reg[0] <= cfg_wdata;
                    rk4msd_pkg::REG_FORCE_Y:    force_reg[1] <= cfg_wdata;
                    rk4msd_pkg::REG_FORCE_Z:    force_reg[2] <= cfg_wdata;
                    default:                    stiff_reg    <= stiff_reg;
                endcase
            end
            if (cmd.load) begin
                for (int i = 0; i < rk4msd_pkg::AXES; i++) begin
                    pos_reg[i] <= start[32*i +: 32];
                    vel_reg[i] <= '0;
                    acc_reg[i] <= '0;
                end
            end
            else if (cmd.write && (cmd.op == rk4msd_pkg::OP_STORE)) begin
                pos_reg[cmd.ax] <= x_reg;
                vel_reg[cmd.ax] <= v_reg;
                acc_reg[cmd.ax] <= kv_reg;
            end
        end
    end

    // Advance the working registers of one axis
    always_ff @(posedge clk)
    begin
        if (cmd.issue) begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.write) begin
            unique case (cmd.op)
                rk4msd_pkg::OP_INIT:
                begin
                    x_reg  <= pos_reg[cmd.ax];
                    v_reg  <= vel_reg[cmd.ax];
                    xe_reg <= pos_reg[cmd.ax];
                    ve_reg <= vel_reg[cmd.ax];
                    sx_reg <= '0;
                    sv_reg <= '0;
                end
                rk4msd_pkg::OP_P, rk4msd_pkg::OP_S: p_reg <= clipped;
                rk4msd_pkg::OP_Q:  q_reg  <= clipped;
                rk4msd_pkg::OP_F:  kv_reg <= clipped;
                rk4msd_pkg::OP_ACC1:
                begin
                    sx_reg <= sx_reg + 36'(ve_reg);
                    sv_reg <= sv_reg + 36'(kv_reg);
                end
                rk4msd_pkg::OP_ACC2:
                begin
                    sx_reg <= sx_reg + (36'(ve_reg) <<< 1);
                    sv_reg <= sv_reg + (36'(kv_reg) <<< 1);
                end
                rk4msd_pkg::OP_DTX_H, rk4msd_pkg::OP_DTX_F: xe_reg <= clipped;
                rk4msd_pkg::OP_DTV_H, rk4msd_pkg::OP_DTV_F: ve_reg <= clipped;
                rk4msd_pkg::OP_FX:
                begin
                    x_reg  <= clipped;
                    xe_reg <= clipped;
                end
                rk4msd_pkg::OP_FV:
                begin
                    v_reg  <= clipped;
                    ve_reg <= clipped;
                end
                default:
                begin
                    x_reg <= x_reg;
                end
            endcase
        end
        if (cmd.publish) begin
            result_reg <= {7'd0, sat_reg,
                           acc_reg[2], acc_reg[1], acc_reg[0],
                           vel_reg[2], vel_reg[1], vel_reg[0],
                           pos_reg[2], pos_reg[1], pos_reg[0]};
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/rk4_mass_spring_damper_step.sv @@
// Top level of the three-axis RK4 mass-spring-damper integrator.
//
//  channel | dir | handshake         | content
//  s_      | in  | s_tvalid/s_tready | tuser: action; tdata: start_x, start_y, start_z
//  m_      | out | m_tvalid/m_tready | tdata: pos xyz, vel xyz, acc xyz, saturated
//  cfg_    | in  | cfg_we            | cfg_addr register index, cfg_wdata value
//
// In a step item, each axis in turn runs a 34-op micro-program on one shared 36x33
// multiplier; each op multiplies, then rounds, adds and clamps. One item is in work
// at a time; a finished result waits in the output register while the next item is
// accepted. Reset clears state and configuration to their defaults; no clearing pass.
module rk4_mass_spring_damper_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [0:0]                      s_tuser,  // action
    input  logic [rk4msd_pkg::IN_W-1:0]     s_tdata,  // start_x, start_y, start_z
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, saturated, zero pad
    output logic [rk4msd_pkg::OUT_W-1:0]    m_tdata,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_addr,
    input  logic [31:0]                     cfg_wdata
);

    rk4msd_pkg::cmd_t cmd;

    rk4msd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    rk4msd_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .start     (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .result    (m_tdata)
    );

endmodule

@@ rtl/rk4msd_checker.sv @@
// Port-level checks of the integrator, bound to the top level.
`include "rk4_mass_spring_damper_step_defines.svh"

module rk4msd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [rk4msd_pkg::OUT_W-1:0]    m_tdata
);

    logic step_acc, load_acc;

    assign step_acc = s_tvalid && s_tready && (s_tuser[0] == rk4msd_pkg::ACT_STEP);
    assign load_acc = s_tvalid && s_tready && (s_tuser[0] == rk4msd_pkg::ACT_LOAD);

    // Hold a stalled result
    `RK4_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // Drop ready while a step is in work
    `RK4_ASSERT_NEXT(a_step_busy, step_acc, !s_tready)
    // A load into a free output passes through the flush state and shows its result with no acceleration
    `RK4_ASSERT_IMPL(a_load_result, load_acc && !m_tvalid,
        ##2 (m_tvalid && (m_tdata[288:192] == 97'd0)))
    // Keep ready while no item is accepted
    `RK4_ASSERT_NEXT(a_ready_busy, s_tready && !(s_tvalid && s_tready), s_tready)

endmodule

bind rk4_mass_spring_damper_step rk4msd_checker u_rk4msd_checker (.*);

@@ test/testbench.sv @@
// Self-checking testbench of the three-axis RK4 mass-spring-damper integrator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;
    localparam int RANDOM_ITEMS = 1830;
    localparam int ITEMS_PER_PHASE = 150;
    localparam longint STEP_DT  = 4294967;
    localparam longint STEP_HDT = 2147484;
    localparam longint STEP_DT6 = 715828;

    typedef struct {
        logic [31:0] pos[3];
        logic [31:0] vel[3];
        logic [31:0] acc[3];
        logic        sat;
    } motion_t;

    // One row of the directed table: a register write or an item
    typedef struct {
        bit          is_cfg;
        logic [2:0]  addr;
        logic [31:0] wdata;
        logic        act;
        logic [31:0] start[3];
        bit          typed;
        motion_t     want;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [0:0]   s_tuser;
    logic [rk4msd_pkg::IN_W-1:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [rk4msd_pkg::OUT_W-1:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_wdata;

    // Shadow of the block's configuration and state
    logic [30:0]        k_spring;
    logic [30:0]        c_damp;
    logic [30:0]        minv[3];
    logic signed [31:0] frc[3];
    logic signed [31:0] pos_now[3];
    logic signed [31:0] vel_now[3];
    bit                 clamp_hit;

    motion_t motion_due[$];
    row_t    plan[$];
    bit      failed;
    bit      calm;
    bit      hold_req;
    int      stall_cnt;

    rk4_mass_spring_damper_step DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic signed [31:0] sat32(input longint v);
        if (v > 64'sd2147483647)
        begin
            clamp_hit = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            clamp_hit = 1'b1;
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Round half away from zero while dropping s fraction bits
    function automatic longint round_off(input longint p, input int s);
        longint unsigned m;
        longint unsigned r;
        m = (p < 0) ? longint'(-p) : p;
        r = (m + (64'd1 << (s - 1))) >> s;
        return (p < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic signed [31:0] qprod(input longint a, input longint b);
        return sat32(round_off(a * b, FRAC));
    endfunction

    function automatic logic signed [31:0] dtprod(input longint a, input longint c);
        return sat32(round_off(a * c, 32));
    endfunction

    function automatic logic signed [31:0] spring_accel(input int ax,
            input logic signed [31:0] x, input logic signed [31:0] v);
        logic signed [31:0] p;
        logic signed [31:0] q;
        logic signed [31:0] s;
        p = qprod(longint'(c_damp), longint'(v));
        q = qprod(longint'(k_spring), longint'(x));
        s = sat32(longint'(frc[ax]) - longint'(p) - longint'(q));
        return qprod(longint'(s), longint'(minv[ax]));
    endfunction

    // Advance the shadow state by one item and return its result
    function automatic motion_t integrate(input logic act, input logic [31:0] st[3]);
        motion_t r;
        logic signed [31:0] x, v, k1v, x2, k2x, k2v, x3, k3x, k3v, x4, k4x, k4v;
        longint sx, sv;
        clamp_hit = 1'b0;
        for (int ax = 0; ax < 3; ax++)
        begin
            r.acc[ax] = '0;
            if (act == rk4msd_pkg::ACT_LOAD)
            begin
                pos_now[ax] = st[ax];
                vel_now[ax] = '0;
            end
            else
            begin
                x = pos_now[ax];
                v = vel_now[ax];
                k1v = spring_accel(ax, x, v);
                x2  = sat32(longint'(x) + dtprod(v, STEP_HDT));
                k2x = sat32(longint'(v) + dtprod(k1v, STEP_HDT));
                k2v = spring_accel(ax, x2, k2x);
                x3  = sat32(longint'(x) + dtprod(k2x, STEP_HDT));
                k3x = sat32(longint'(v) + dtprod(k2v, STEP_HDT));
                k3v = spring_accel(ax, x3, k3x);
                x4  = sat32(longint'(x) + dtprod(k3x, STEP_DT));
                k4x = sat32(longint'(v) + dtprod(k3v, STEP_DT));
                k4v = spring_accel(ax, x4, k4x);
                sx = longint'(v) + 2 * longint'(k2x) + 2 * longint'(k3x) + longint'(k4x);
                sv = longint'(k1v) + 2 * longint'(k2v) + 2 * longint'(k3v)
                    + longint'(k4v);
                pos_now[ax] = sat32(longint'(x) + round_off(sx * STEP_DT6, 32));
                vel_now[ax] = sat32(longint'(v) + round_off(sv * STEP_DT6, 32));
                r.acc[ax] = spring_accel(ax, pos_now[ax], vel_now[ax]);
            end
        end
        for (int ax = 0; ax < 3; ax++)
        begin
            r.pos[ax] = pos_now[ax];
            r.vel[ax] = vel_now[ax];
        end
        r.sat = clamp_hit;
        return r;
    endfunction

    // Mirror a register write into the shadow configuration
    function automatic void shadow_reg(input logic [2:0] addr, input logic [31:0] val);
        case (addr)
            rk4msd_pkg::REG_STIFFNESS:  k_spring = val[30:0];
            rk4msd_pkg::REG_DAMPING:    c_damp = val[30:0];
            rk4msd_pkg::REG_INV_MASS_X: minv[0] = val[30:0];
            rk4msd_pkg::REG_INV_MASS_Y: minv[1] = val[30:0];
            rk4msd_pkg::REG_INV_MASS_Z: minv[2] = val[30:0];
            rk4msd_pkg::REG_FORCE_X:    frc[0] = val;
            rk4msd_pkg::REG_FORCE_Y:    frc[1] = val;
            default:                    frc[2] = val;
        endcase
    endfunction

    // Hold until every expected result has come out, then settle
    task automatic drain();
        while (motion_due.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        shadow_reg(addr, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Offer one item, wait for its acceptance and queue its result
    task automatic send_item(input logic act, input logic [31:0] st[3],
            input bit typed, input motion_t want);
        motion_t got;
        while (!calm && $urandom_range(0, 99) < 6)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser = act;
        s_tdata = {st[2], st[1], st[0]};
        do
            @(posedge clk);
        while (!s_tready);
        got = integrate(act, st);
        motion_due.push_back(typed ? want : got);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [31:0] rand_word(input bit wide_only);
        logic [31:0] w;
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = 32'h7FFF_FFFF;
            2: w = 32'h8000_0000;
            3, 4, 5, 6:
            begin
                w = $urandom_range(0, 1 << 20);
                if ($urandom_range(0, 1) == 1)
                    w = -w;
            end
            default: w = $urandom;
        endcase
        if (wide_only && w == '0)
            w = $urandom;
        return w;
    endfunction

    function automatic void add_cfg(input logic [2:0] addr, input logic [31:0] val);
        row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.addr = addr;
        r.wdata = val;
        plan.push_back(r);
    endfunction

    // Item row; a typed load row expects the start position back with zero velocity, a typed step row all zeros
    function automatic void add_item(input logic act, input logic [31:0] a,
            input logic [31:0] b, input logic [31:0] c, input bit typed);
        row_t r;
        r = '{default: '0};
        r.act = act;
        r.start[0] = a;
        r.start[1] = b;
        r.start[2] = c;
        r.typed = typed;
        r.want.pos[0] = (act == rk4msd_pkg::ACT_LOAD) ? a : '0;
        r.want.pos[1] = (act == rk4msd_pkg::ACT_LOAD) ? b : '0;
        r.want.pos[2] = (act == rk4msd_pkg::ACT_LOAD) ? c : '0;
        plan.push_back(r);
    endfunction

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        motion_t exp_m;
        string ax_name;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (motion_due.size() == 0)
            begin
                $error("result with no expectation waiting");
                failed = 1'b1;
            end
            else
            begin
                exp_m = motion_due.pop_front();
                for (int ax = 0; ax < 3; ax++)
                begin
                    ax_name = (ax == 0) ? "x" : (ax == 1) ? "y" : "z";
                    if (m_tdata[32*ax +: 32] !== exp_m.pos[ax])
                    begin
                        $error("pos_%s expected %h actual %h", ax_name, exp_m.pos[ax],
                            m_tdata[32*ax +: 32]);
                        failed = 1'b1;
                    end
                    if (m_tdata[96 + 32*ax +: 32] !== exp_m.vel[ax])
                    begin
                        $error("vel_%s expected %h actual %h", ax_name, exp_m.vel[ax],
                            m_tdata[96 + 32*ax +: 32]);
                        failed = 1'b1;
                    end
                    if (m_tdata[192 + 32*ax +: 32] !== exp_m.acc[ax])
                    begin
                        $error("acc_%s expected %h actual %h", ax_name, exp_m.acc[ax],
                            m_tdata[192 + 32*ax +: 32]);
                        failed = 1'b1;
                    end
                end
                if (m_tdata[288] !== exp_m.sat)
                begin
                    $error("saturated expected %b actual %b", exp_m.sat, m_tdata[288]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            m_tready = calm || ($urandom_range(0, 99) >= 6);
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] st[3];
        motion_t none;
        int sent;
        failed = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        stall_cnt = 0;
        none = '{default: '0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = '0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = rk4msd_pkg::REG_STIFFNESS;
        cfg_wdata = '0;
        k_spring = '0;
        c_damp = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            minv[ax] = 31'd1 << FRAC;
            frc[ax] = '0;
            pos_now[ax] = '0;
            vel_now[ax] = '0;
        end

        // Directed table: reset defaults, extremes, overflow, masked register bits
        add_item(rk4msd_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 1'b1);
        add_item(rk4msd_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
        add_item(rk4msd_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 1'b0);
        add_item(rk4msd_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000, 1'b1);
        add_cfg(rk4msd_pkg::REG_STIFFNESS, 32'hFFFF_FFFF);
        add_cfg(rk4msd_pkg::REG_DAMPING, 32'h7FFF_FFFF);
        add_cfg(rk4msd_pkg::REG_INV_MASS_X, 32'h7FFF_FFFF);
        add_cfg(rk4msd_pkg::REG_INV_MASS_Y, 32'h0);
        add_cfg(rk4msd_pkg::REG_INV_MASS_Z, 32'h8001_0000);
        add_cfg(rk4msd_pkg::REG_FORCE_X, 32'h7FFF_FFFF);
        add_cfg(rk4msd_pkg::REG_FORCE_Y, 32'h8000_0000);
        add_cfg(rk4msd_pkg::REG_FORCE_Z, 32'h0000_8000);
        add_item(rk4msd_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 1'b0);
        add_item(rk4msd_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        add_item(rk4msd_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 1'b0);
        add_item(rk4msd_pkg::ACT_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_cfg(rk4msd_pkg::REG_STIFFNESS, 32'h0004_0000);
        add_cfg(rk4msd_pkg::REG_DAMPING, 32'h0000_8000);
        add_cfg(rk4msd_pkg::REG_INV_MASS_X, 32'h0001_0000);
        add_cfg(rk4msd_pkg::REG_FORCE_X, 32'hFFF0_0000);
        add_item(rk4msd_pkg::ACT_LOAD, 32'h0010_0000, 32'h0, 32'hFFF0_0000, 1'b1);
        add_item(rk4msd_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 1'b0);
        add_item(rk4msd_pkg::ACT_STEP, 32'h0, 32'h0, 32'h0, 1'b0);

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].addr, plan[i].wdata);
            end
            else
                send_item(plan[i].act, plan[i].start, plan[i].typed, plan[i].want);
        end

        // Random phases: new settings, then a load followed mostly by steps
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain();
            write_reg(rk4msd_pkg::REG_STIFFNESS, rand_word(1'b0));
            write_reg(rk4msd_pkg::REG_DAMPING, rand_word(1'b0));
            write_reg(rk4msd_pkg::REG_INV_MASS_X, rand_word(1'b1));
            write_reg(rk4msd_pkg::REG_INV_MASS_Y, rand_word(1'b1));
            write_reg(rk4msd_pkg::REG_INV_MASS_Z, rand_word(1'b1));
            write_reg(rk4msd_pkg::REG_FORCE_X, rand_word(1'b0));
            write_reg(rk4msd_pkg::REG_FORCE_Y, rand_word(1'b0));
            write_reg(rk4msd_pkg::REG_FORCE_Z, rand_word(1'b0));
            for (int n = 0; n < ITEMS_PER_PHASE && sent < RANDOM_ITEMS; n++)
            begin
                for (int ax = 0; ax < 3; ax++)
                    st[ax] = rand_word(1'b0);
                calm = (sent >= 600 && sent < 800);
                if (sent == 300)
                    hold_req = 1'b1;
                send_item((n == 0 || $urandom_range(0, 99) < 15) ?
                    rk4msd_pkg::ACT_LOAD : rk4msd_pkg::ACT_STEP,
                    st, 1'b0, none);
                sent++;
            end
        end

        calm = 1'b0;
        drain();
        repeat (250) @(negedge clk);
        if (!failed && motion_due.size() == 0)
            $display("TEST PASSED");
        else
        begin
            if (motion_due.size() != 0)
                $error("%0d expected results never arrived", motion_due.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
